### rtl/mrw_pkg.sv
// ============================================================================
// mrw_pkg: shared types and constants for the Miller-Rabin witness test
// Holds the default operand width, verdict codes, the unit control and status structs and the sequencer states.
// ============================================================================
package mrw_pkg;

    localparam int NUM_WIDTH_DEF = 62;

    typedef enum logic [1:0] {
        VERDICT_COMPOSITE = 2'd0,
        VERDICT_PRIME     = 2'd1,
        VERDICT_INVALID   = 2'd2
    } verdict_t;

    // Requests from the sequencer to the modular multiplier and the gcd unit.
    typedef struct packed {
        logic start;
    } mul_ctrl_t;

    typedef struct packed {
        logic busy;
        logic done;
    } mul_stat_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CHECK,
        ST_GCD,
        ST_SPLIT,
        ST_POW_SEL,
        ST_POW_MUL_R,
        ST_POW_MUL_B,
        ST_POW_TEST,
        ST_SQR,
        ST_SQR_TEST,
        ST_DONE
    } state_t;

endpackage

### rtl/miller_rabin_witness_test_core.sv
// Special cases go from the check state straight to the done state; a full round also runs
// the gcd unit, square-and-multiply and the squaring chain on the multiplier.
// Throughput: one item at a time; the shared bit-serial multiplier sets it.
// Reset: rst_n asynchronous, active low; clears the sequencer and output.
// ============================================================================
// miller_rabin_witness_test_core: one Miller-Rabin round per item
// A sequencer drives a shared modular multiplier and a binary gcd unit.
// ============================================================================
module miller_rabin_witness_test_core #(
    parameter int NUM_WIDTH = mrw_pkg::NUM_WIDTH_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic [NUM_WIDTH-1:0] candidate,
    input  logic [NUM_WIDTH-1:0] witness,
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic [1:0]           verdict
);
    import mrw_pkg::*;

    localparam int SW = $clog2(NUM_WIDTH + 1);

    state_t               state_reg, state_next;
    logic [NUM_WIDTH-1:0] n_reg, n_next, a_reg, a_next;
    logic [NUM_WIDTH-1:0] t_reg, t_next, r_reg, r_next, b_reg, b_next;
    logic [SW-1:0]        s_reg, s_next;
    logic                 ov_reg, ov_next;
    verdict_t             vd_reg, vd_next;
    verdict_t             rv_reg, rv_next;

    mul_ctrl_t            mul_ctrl, gcd_ctrl;
    mul_stat_t            mul_stat, gcd_stat;
    logic [NUM_WIDTH-1:0] mx, my, prod;
    logic                 coprime;
    logic [NUM_WIDTH-1:0] nm1;

    assign nm1 = n_reg - 1'b1;

    mrw_modmul #(.NUM_WIDTH(NUM_WIDTH)) u_mul (
        .clk(clk), .rst_n(rst_n), .ctrl(mul_ctrl), .x(mx), .y(my), .m(n_reg),
        .stat(mul_stat), .prod(prod)
    );

    mrw_gcd #(.NUM_WIDTH(NUM_WIDTH)) u_gcd (
        .clk(clk), .rst_n(rst_n), .ctrl(gcd_ctrl), .a(a_reg), .b(n_reg),
        .stat(gcd_stat), .coprime(coprime)
    );

    assign in_stall = (state_reg != ST_IDLE);

    // Sequencer: checks, gcd, square-and-multiply, then the squaring chain.
    // The verdict is built in rv_reg and only moves to the output register in
    // the done state, so a waiting result never changes.
    always_comb
    begin
        state_next     = state_reg;
        n_next         = n_reg;
        a_next         = a_reg;
        t_next         = t_reg;
        r_next         = r_reg;
        b_next         = b_reg;
        s_next         = s_reg;
        ov_next        = ov_reg;
        vd_next        = vd_reg;
        rv_next        = rv_reg;
        mul_ctrl.start = 1'b0;
        gcd_ctrl.start = 1'b0;
        mx             = r_reg;
        my             = b_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    n_next     = candidate;
                    a_next     = witness;
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                state_next = ST_DONE;
                if (n_reg == '0)
                    rv_next = VERDICT_INVALID;
                else if (n_reg == NUM_WIDTH'(1))
                    rv_next = VERDICT_COMPOSITE;
                else if (n_reg == NUM_WIDTH'(2))
                    rv_next = VERDICT_PRIME;
                else if (a_reg < NUM_WIDTH'(2) || a_reg > nm1)
                    rv_next = VERDICT_INVALID;
                else if (!n_reg[0])
                    rv_next = VERDICT_COMPOSITE;
                else
                begin
                    gcd_ctrl.start = 1'b1;
                    t_next         = nm1;
                    s_next         = '0;
                    state_next     = ST_GCD;
                end
            end
            ST_GCD:
            begin
                if (gcd_stat.done)
                begin
                    if (!coprime)
                    begin
                        rv_next    = VERDICT_COMPOSITE;
                        state_next = ST_DONE;
                    end
                    else
                        state_next = ST_SPLIT;
                end
            end
            ST_SPLIT:
            begin
                if (!t_reg[0])
                begin
                    t_next = t_reg >> 1;
                    s_next = s_reg + 1'b1;
                end
                else
                begin
                    r_next     = NUM_WIDTH'(1);
                    b_next     = a_reg;
                    state_next = ST_POW_SEL;
                end
            end
            ST_POW_SEL:
            begin
                if (t_reg == '0)
                    state_next = ST_POW_TEST;
                else if (t_reg[0])
                begin
                    mul_ctrl.start = 1'b1;
                    state_next     = ST_POW_MUL_R;
                end
                else
                begin
                    mx             = b_reg;
                    mul_ctrl.start = 1'b1;
                    state_next     = ST_POW_MUL_B;
                end
            end
            ST_POW_MUL_R:
            begin
                if (mul_stat.done)
                begin
                    r_next         = prod;
                    mx             = b_reg;
                    mul_ctrl.start = 1'b1;
                    state_next     = ST_POW_MUL_B;
                end
            end
            ST_POW_MUL_B:
            begin
                mx = b_reg;
                if (mul_stat.done)
                begin
                    b_next     = prod;
                    t_next     = t_reg >> 1;
                    state_next = ST_POW_SEL;
                end
            end
            ST_POW_TEST:
            begin
                if (r_reg == NUM_WIDTH'(1) || r_reg == nm1)
                begin
                    rv_next    = VERDICT_PRIME;
                    state_next = ST_DONE;
                end
                else if (s_reg <= SW'(1))
                begin
                    rv_next    = VERDICT_COMPOSITE;
                    state_next = ST_DONE;
                end
                else
                begin
                    s_next         = s_reg - 1'b1;
                    my             = r_reg;
                    mul_ctrl.start = 1'b1;
                    state_next     = ST_SQR;
                end
            end
            ST_SQR:
            begin
                my = r_reg;
                if (mul_stat.done)
                begin
                    r_next     = prod;
                    state_next = ST_SQR_TEST;
                end
            end
            ST_SQR_TEST:
            begin
                my = r_reg;
                if (r_reg == nm1)
                begin
                    rv_next    = VERDICT_PRIME;
                    state_next = ST_DONE;
                end
                else if (r_reg == NUM_WIDTH'(1) || s_reg <= SW'(1))
                begin
                    rv_next    = VERDICT_COMPOSITE;
                    state_next = ST_DONE;
                end
                else
                begin
                    s_next         = s_reg - 1'b1;
                    mul_ctrl.start = 1'b1;
                    state_next     = ST_SQR;
                end
            end
            ST_DONE:
            begin
                if (!ov_reg || !out_stall)
                begin
                    ov_next    = 1'b1;
                    vd_next    = rv_reg;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
        if (ov_reg && !out_stall && !(state_reg == ST_DONE))
            ov_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            ov_reg    <= 1'b0;
            vd_reg    <= VERDICT_COMPOSITE;
        end
        else
        begin
            state_reg <= state_next;
            ov_reg    <= ov_next;
            vd_reg    <= vd_next;
        end
    end

    always_ff @(posedge clk)
    begin
        n_reg  <= n_next;
        a_reg  <= a_next;
        t_reg  <= t_next;
        r_reg  <= r_next;
        b_reg  <= b_next;
        s_reg  <= s_next;
        rv_reg <= rv_next;
    end

    assign out_valid = ov_reg;
    assign verdict   = vd_reg;

    // A multiply is only started while the unit is free.
    a_mul_free: assert property (@(posedge clk) disable iff (!rst_n)
        mul_ctrl.start |-> !mul_stat.busy)
        else $error("multiplier restarted while busy");
    // An item offered while idle is always taken into the check state.
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_IDLE && in_valid |=> state_reg == ST_CHECK)
        else $error("item not taken");
    // The verdict code is never the unused value.
    a_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> verdict != 2'd3)
        else $error("unused verdict code");

endmodule

### rtl/mrw_modmul.sv
// ============================================================================
// mrw_modmul: bit-serial modular multiplier
// Computes (x * y) mod m with one MSB-first shift-and-add step per cycle.
// ============================================================================
module mrw_modmul #(
    parameter int NUM_WIDTH = mrw_pkg::NUM_WIDTH_DEF
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  mrw_pkg::mul_ctrl_t     ctrl,
    input  logic [NUM_WIDTH-1:0]   x,
    input  logic [NUM_WIDTH-1:0]   y,
    input  logic [NUM_WIDTH-1:0]   m,
    output mrw_pkg::mul_stat_t     stat,
    output logic [NUM_WIDTH-1:0]   prod
);
    import mrw_pkg::*;

    localparam int CW = $clog2(NUM_WIDTH + 1);

    logic [NUM_WIDTH-1:0] acc_reg, acc_next;
    logic [NUM_WIDTH-1:0] y_reg, y_next;
    logic [CW-1:0]        cnt_reg, cnt_next;
    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [NUM_WIDTH:0]   dbl;
    logic [NUM_WIDTH-1:0] dbl_red;
    logic [NUM_WIDTH:0]   add;
    logic [NUM_WIDTH-1:0] add_red;

    // One step: double, reduce, then add x under the current bit and reduce.
    always_comb
    begin
        dbl     = {acc_reg, 1'b0};
        dbl_red = (dbl >= {1'b0, m}) ? NUM_WIDTH'(dbl - {1'b0, m}) : dbl[NUM_WIDTH-1:0];
        add     = {1'b0, dbl_red} + {1'b0, x};
        add_red = (add >= {1'b0, m}) ? NUM_WIDTH'(add - {1'b0, m}) : add[NUM_WIDTH-1:0];
    end

    always_comb
    begin
        acc_next  = acc_reg;
        y_next    = y_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (ctrl.start && !busy_reg)
        begin
            acc_next  = '0;
            y_next    = y;
            cnt_next  = CW'(NUM_WIDTH);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            acc_next = y_reg[NUM_WIDTH-1] ? add_red : dbl_red;
            y_next   = {y_reg[NUM_WIDTH-2:0], 1'b0};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CW'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
        y_reg   <= y_next;
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign prod      = acc_reg;

    // The step counter only runs while busy.
    a_cnt_idle: assert property (@(posedge clk) disable iff (!rst_n)
        !busy_reg |-> cnt_reg == '0 || $past(busy_reg))
        else $error("step counter active while idle");
    // Done is a single pulse that ends a busy run.
    a_done: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> !busy_reg && $past(busy_reg))
        else $error("done without a preceding run");
    // The accumulator stays reduced below the modulus.
    a_red: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg && m != '0 |-> acc_reg < m)
        else $error("product not reduced");

endmodule

### rtl/mrw_gcd.sv
// ============================================================================
// mrw_gcd: binary gcd unit
// Finds gcd(a, b), reported as coprime, with one shift, subtract or swap step per cycle.
// ============================================================================
module mrw_gcd #(
    parameter int NUM_WIDTH = mrw_pkg::NUM_WIDTH_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  mrw_pkg::mul_ctrl_t   ctrl,
    input  logic [NUM_WIDTH-1:0] a,
    input  logic [NUM_WIDTH-1:0] b,
    output mrw_pkg::mul_stat_t   stat,
    output logic                 coprime
);
    import mrw_pkg::*;

    // b is odd (n odd), so the common factor of two never arises.
    logic [NUM_WIDTH-1:0] u_reg, u_next, v_reg, v_next;
    logic                 busy_reg, busy_next, done_reg, done_next;
    logic [NUM_WIDTH-1:0] diff;

    always_comb
    begin
        u_next    = u_reg;
        v_next    = v_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        diff      = u_reg - v_reg;
        if (ctrl.start && !busy_reg)
        begin
            u_next    = a;
            v_next    = b;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (u_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
            else if (!u_reg[0])
                u_next = u_reg >> 1;
            else if (u_reg >= v_reg)
                u_next = diff >> 1;
            else
            begin
                u_next = v_reg - u_reg;
                v_next = u_reg;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        u_reg <= u_next;
        v_reg <= v_next;
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign coprime   = (v_reg == NUM_WIDTH'(1));

    // Done follows a busy cycle and ends the run.
    a_done: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> $past(busy_reg) && !busy_reg)
        else $error("gcd done without run");
    // The run stops only once u has reached zero.
    a_stop: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(busy_reg) |-> $past(u_reg) == '0)
        else $error("gcd stopped early");
    // v stays odd through a run.
    a_odd: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg && $past(busy_reg) && $past(v_reg[0]) |-> v_reg[0])
        else $error("gcd lost odd operand");

endmodule
